[hw/rtl/sjc_pkg.sv]
// Package for the skeleton junction classifier.
// Holds sizes, register addresses and the types shared by the sjc_* modules.
// No dependencies.
package sjc_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = 16;
  localparam int LW_W       = 12;
  localparam int CNT_W      = (COL_W + 1 > LW_W) ? COL_W + 1 : LW_W;
  localparam int RUN_W      = 3;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int MIN_WIDTH  = 3;
  localparam int LW_RESET   = 640;

  localparam logic [ROW_W-1:0] ROW_MAX = '1;

  // word address of the line_width register (paddr[APB_ADDR_W-1:2])
  localparam logic [APB_ADDR_W-3:0] REG_LINE_WIDTH = '0;

  typedef struct packed {
    logic upper;
    logic middle;
  } line_word_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             pixel;
    logic             fwd;
    line_word_t       fwd_word;
  } s1_item_t;

  typedef struct packed {
    logic             result_valid;
    logic [COL_W-1:0] center_col;
    logic [ROW_W-1:0] center_row;
    logic             center_pixel;
    logic [RUN_W-1:0] run_count;
    logic             is_junction;
    logic             is_endpoint;
  } result_t;

endpackage

[hw/rtl/skeleton_junction_classifier.sv]
// Top level of the skeleton junction classifier: position counters, line memory
// access with forwarding, window stage and output register.
// Depends on sjc_pkg, sjc_apb_regs, sjc_line_mem, sjc_window.
//
//   channel  handshake                  payload
//   in       in_valid / in_ready        start_of_frame, pixel
//   out      out_valid / out_ready      result_valid .. is_endpoint
//   cfg      APB psel/penable/pwrite    paddr, pwdata, prdata
//
// One pixel per cycle unless the output stalls; an accepted item enters stage 1
// (memory read on the accepting edge), then window, classify and output register.
// After reset all 2048 line memory columns are zeroed, one column per cycle, and
// in_ready stays low meanwhile. A stalled output holds stage 1; after the clear,
// in_ready drops only while stage 1 and the output register are both full.
module skeleton_junction_classifier (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            start_of_frame,
  input  logic                            pixel,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            result_valid,
  output logic [sjc_pkg::COL_W-1:0]       center_col,
  output logic [sjc_pkg::ROW_W-1:0]       center_row,
  output logic                            center_pixel,
  output logic [sjc_pkg::RUN_W-1:0]       run_count,
  output logic                            is_junction,
  output logic                            is_endpoint,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sjc_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [sjc_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [sjc_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);

  logic [sjc_pkg::LW_W-1:0]   line_width;
  logic [sjc_pkg::CNT_W-1:0]  eff_width;
  logic [sjc_pkg::CNT_W-1:0]  lw_ext;

  logic                       clearing;
  logic [sjc_pkg::COL_W-1:0]  clear_addr;

  logic [sjc_pkg::COL_W-1:0]  col_cnt;
  logic [sjc_pkg::ROW_W-1:0]  row_cnt;
  logic [sjc_pkg::COL_W-1:0]  cur_col;
  logic [sjc_pkg::ROW_W-1:0]  cur_row;
  logic [sjc_pkg::COL_W-1:0]  col_cnt_next;
  logic [sjc_pkg::ROW_W-1:0]  row_cnt_next;

  logic                       accept;
  logic                       out_free;
  logic                       s1_move;
  logic                       s1_valid;
  sjc_pkg::s1_item_t          s1;
  logic                       fwd;

  sjc_pkg::line_word_t        rd_word;
  sjc_pkg::line_word_t        wr_word;
  sjc_pkg::line_word_t        mem_wr_data;
  logic [sjc_pkg::COL_W-1:0]  mem_wr_addr;
  logic                       mem_wr_en;

  sjc_pkg::result_t           res;
  sjc_pkg::result_t           res_q;

  sjc_apb_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .line_width (line_width)
  );

  // effective row width, clamped to MIN_WIDTH..MAX_WIDTH
  assign lw_ext = sjc_pkg::CNT_W'(line_width);
  always_comb begin
    eff_width = lw_ext;
    if (lw_ext < sjc_pkg::CNT_W'(sjc_pkg::MIN_WIDTH)) begin
      eff_width = sjc_pkg::CNT_W'(sjc_pkg::MIN_WIDTH);
    end else if (lw_ext > sjc_pkg::CNT_W'(sjc_pkg::MAX_WIDTH)) begin
      eff_width = sjc_pkg::CNT_W'(sjc_pkg::MAX_WIDTH);
    end
  end

  assign out_free = !out_valid || out_ready;
  assign s1_move  = s1_valid && out_free;
  assign in_ready = !clearing && (!s1_valid || out_free);
  assign accept   = in_valid && in_ready;

  assign cur_col = start_of_frame ? '0 : col_cnt;
  assign cur_row = start_of_frame ? '0 : row_cnt;

  always_comb begin
    col_cnt_next = cur_col + sjc_pkg::COL_W'(1);
    row_cnt_next = cur_row;
    if (sjc_pkg::CNT_W'(cur_col) + sjc_pkg::CNT_W'(1) >= eff_width) begin
      col_cnt_next = '0;
      if (cur_row != sjc_pkg::ROW_MAX) begin
        row_cnt_next = cur_row + sjc_pkg::ROW_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (accept) begin
      col_cnt <= col_cnt_next;
      row_cnt <= row_cnt_next;
    end
  end

  // memory clear after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clear_addr <= '0;
    end else if (clearing) begin
      clear_addr <= clear_addr + sjc_pkg::COL_W'(1);
      if (clear_addr == '1) begin
        clearing <= 1'b0;
      end
    end
  end

  // write-back of stage 1 lands on the same edge as this read
  assign fwd = s1_move && (s1.col == cur_col);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1.col      <= cur_col;
      s1.row      <= cur_row;
      s1.pixel    <= pixel;
      s1.fwd      <= fwd;
      s1.fwd_word <= wr_word;
    end
  end

  assign mem_wr_en   = clearing || s1_move;
  assign mem_wr_addr = clearing ? clear_addr : s1.col;
  assign mem_wr_data = clearing ? '0 : wr_word;

  sjc_line_mem u_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (cur_col),
    .rd_data (rd_word),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  sjc_window u_window (
    .clk     (clk),
    .rst     (rst),
    .s1      (s1),
    .rd_word (rd_word),
    .advance (s1_move),
    .wr_word (wr_word),
    .result  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      res_q <= res;
    end
  end

  assign result_valid = res_q.result_valid;
  assign center_col   = res_q.center_col;
  assign center_row   = res_q.center_row;
  assign center_pixel = res_q.center_pixel;
  assign run_count    = res_q.run_count;
  assign is_junction  = res_q.is_junction;
  assign is_endpoint  = res_q.is_endpoint;

  a_stage1_held: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_free |=> s1_valid && $stable(s1.col) && $stable(s1.row))
    else $error("stage 1 transaction lost while output stalled");

  a_clear_sweep: assert property (@(posedge clk) disable iff (rst)
    clearing && !$past(rst) |=> !clearing || clear_addr == $past(clear_addr) + 1'b1)
    else $error("clear sweep skipped a column");

  a_runs_need_center: assert property (@(posedge clk) disable iff (rst)
    out_valid && run_count != '0 |-> center_pixel && result_valid)
    else $error("runs reported without a foreground center");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(is_junction && is_endpoint))
    else $error("junction and endpoint both set");

endmodule

[hw/rtl/sjc_apb_regs.sv]
// APB register file for the classifier: holds line_width.
// Depends on sjc_pkg.
module sjc_apb_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sjc_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [sjc_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [sjc_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  output logic [sjc_pkg::LW_W-1:0]        line_width
);

  logic hit;

  assign hit    = (paddr[sjc_pkg::APB_ADDR_W-1:2] == sjc_pkg::REG_LINE_WIDTH);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= sjc_pkg::LW_W'(sjc_pkg::LW_RESET);
    end else if (psel && penable && pwrite && pready && hit) begin
      line_width <= pwdata[sjc_pkg::LW_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (hit) begin
      prdata = sjc_pkg::APB_DATA_W'(line_width);
    end
  end

endmodule

[hw/rtl/sjc_line_mem.sv]
// Line buffer memory: one word per column holding the upper and middle row bits.
// One write port, one registered read port. Depends on sjc_pkg.
module sjc_line_mem (
  input  logic                        clk,
  input  logic                        rd_en,
  input  logic [sjc_pkg::COL_W-1:0]   rd_addr,
  output sjc_pkg::line_word_t         rd_data,
  input  logic                        wr_en,
  input  logic [sjc_pkg::COL_W-1:0]   wr_addr,
  input  sjc_pkg::line_word_t         wr_data
);

  sjc_pkg::line_word_t mem [sjc_pkg::MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hw/rtl/sjc_window.sv]
// 3x3 window and crossing-number classification for the item in stage 1.
// Builds the memory write-back word and the result. Depends on sjc_pkg.
module sjc_window (
  input  logic                        clk,
  input  logic                        rst,
  input  sjc_pkg::s1_item_t           s1,
  input  sjc_pkg::line_word_t         rd_word,
  input  logic                        advance,
  output sjc_pkg::line_word_t         wr_word,
  output sjc_pkg::result_t            result
);

  sjc_pkg::line_word_t     word;
  logic [8:0]              win;
  logic [8:0]              win_next;
  logic [7:0]              ring;
  logic [7:0]              rise;
  logic [sjc_pkg::RUN_W-1:0] runs;
  logic                    center;
  logic                    has_center;
  logic                    inner;

  assign word           = s1.fwd ? s1.fwd_word : rd_word;
  assign wr_word.upper  = word.middle;
  assign wr_word.middle = s1.pixel;

  // bit index = 3*column + row; newest column enters at the top
  assign win_next = {s1.pixel, word.middle, word.upper, win[8:3]};

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (advance) begin
      win <= win_next;
    end
  end

  // N, NE, E, SE, S, SW, W, NW
  assign ring = {win_next[0], win_next[1], win_next[2], win_next[5],
                 win_next[8], win_next[7], win_next[6], win_next[3]};

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      rise[i] = !ring[i] && ring[(i + 1) % 8];
    end
  end

  assign runs       = (&ring) ? sjc_pkg::RUN_W'(1) : sjc_pkg::RUN_W'($countones(rise));
  assign center     = win_next[4];
  assign has_center = (s1.col != '0) && (s1.row != '0);
  assign inner      = (s1.col != sjc_pkg::COL_W'(1)) && (s1.row != sjc_pkg::ROW_W'(1));

  always_comb begin
    result = '0;
    if (has_center) begin
      result.result_valid = 1'b1;
      result.center_col   = s1.col - sjc_pkg::COL_W'(1);
      result.center_row   = s1.row - sjc_pkg::ROW_W'(1);
      result.center_pixel = center;
      if (center && inner) begin
        result.run_count   = runs;
        result.is_junction = (runs > sjc_pkg::RUN_W'(2));
        result.is_endpoint = (runs == sjc_pkg::RUN_W'(1));
      end
    end
  end

endmodule

[test/sjc_result_checker.sv]
// Result checker for skeleton_junction_classifier: mirrors the line buffers, the 3x3
// window and the crossing-number count, and compares every output transaction in order.
// Depends on sjc_pkg; instantiated beside the DUT by skeleton_junction_classifier_tb.
module sjc_result_checker
  import sjc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic                  start_of_frame,
  input  logic                  pixel,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  result_valid,
  input  logic [COL_W-1:0]      center_col,
  input  logic [ROW_W-1:0]      center_row,
  input  logic                  center_pixel,
  input  logic [RUN_W-1:0]      run_count,
  input  logic                  is_junction,
  input  logic                  is_endpoint,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  input  logic [APB_DATA_W-1:0] prdata,
  output int                    pending,
  output int                    errors
);

  result_t              expected_results[$];
  logic [LW_W-1:0]      width_reg;
  logic [MAX_WIDTH-1:0] upper_line;
  logic [MAX_WIDTH-1:0] middle_line;
  logic [8:0]           window;
  int                   col_pos;
  int                   row_pos;

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      errors++;
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    result_t    exp_r;
    result_t    new_r;
    logic       up;
    logic       mid;
    logic [7:0] ring;
    int         col;
    int         row;
    int         eff_width;
    int         runs;
    if (rst) begin
      expected_results.delete();
      width_reg   = LW_W'(LW_RESET);
      upper_line  = '0;
      middle_line = '0;
      window      = '0;
      col_pos     = 0;
      row_pos     = 0;
      errors      = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          errors++;
          $error("result transaction with no expectation pending");
        end else begin
          exp_r = expected_results.pop_front();
          check_field("result_valid", exp_r.result_valid, result_valid);
          check_field("center_col", exp_r.center_col, center_col);
          check_field("center_row", exp_r.center_row, center_row);
          check_field("center_pixel", exp_r.center_pixel, center_pixel);
          check_field("run_count", exp_r.run_count, run_count);
          check_field("is_junction", exp_r.is_junction, is_junction);
          check_field("is_endpoint", exp_r.is_endpoint, is_endpoint);
        end
      end

      if (in_valid && in_ready) begin
        eff_width = (width_reg < MIN_WIDTH) ? MIN_WIDTH :
                    (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
        if (start_of_frame) begin
          col_pos = 0;
          row_pos = 0;
        end
        col = col_pos;
        row = row_pos;
        up  = upper_line[col];
        mid = middle_line[col];
        upper_line[col]  = mid;
        middle_line[col] = pixel;
        // newest column enters at the top bits; bit 3*c + r, r = 0 is the top row
        window = {pixel, mid, up, window[8:3]};
        new_r = '0;
        if (col >= 1 && row >= 1) begin
          // ring[0] = N, then clockwise NE, E, SE, S, SW, W, NW
          ring = {window[0], window[1], window[2], window[5],
                  window[8], window[7], window[6], window[3]};
          runs = 0;
          for (int i = 0; i < 8; i++)
            if (!ring[i] && ring[(i + 1) % 8]) runs++;
          if (&ring) runs = 1;
          if (!window[4] || col == 1 || row == 1) runs = 0;
          new_r.result_valid = 1'b1;
          new_r.center_col   = COL_W'(col - 1);
          new_r.center_row   = ROW_W'(row - 1);
          new_r.center_pixel = window[4];
          new_r.run_count    = RUN_W'(runs);
          new_r.is_junction  = (runs > 2);
          new_r.is_endpoint  = (runs == 1);
        end
        expected_results.push_back(new_r);
        if (col + 1 >= eff_width) begin
          col_pos = 0;
          if (row_pos < ROW_MAX) row_pos++;
        end else begin
          col_pos = col + 1;
        end
      end

      if (psel && penable && pready && paddr[APB_ADDR_W-1:2] == REG_LINE_WIDTH) begin
        if (pwrite) begin
          width_reg = pwdata[LW_W-1:0];
        end else begin
          check_field("prdata", width_reg, prdata[LW_W-1:0]);
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

[test/skeleton_junction_classifier_tb.sv]
// Testbench top for skeleton_junction_classifier: clock, reset, APB setup, raster
// pixel stimulus with idling and back-pressure, watchdog and verdict.
// Depends on sjc_pkg, the DUT and sjc_result_checker.
module skeleton_junction_classifier_tb;
  import sjc_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int PHASE_ITEMS    = 130;
  localparam int WIDE_ITEMS     = 200;
  localparam int NOISE_PER_MILLE = 5;
  localparam logic [APB_ADDR_W-1:0] LINE_WIDTH_ADDR = {REG_LINE_WIDTH, 2'b00};
  localparam logic [APB_ADDR_W-1:0] UNUSED_REG_ADDR = LINE_WIDTH_ADDR + APB_ADDR_W'(4);
  // 5x5 image: diagonal corners, a middle ring open to the south, mixed borders
  localparam logic [24:0] CROSS_PATTERN = 25'b10101_01110_11111_01010_10101;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic                  start_of_frame;
  logic                  pixel;
  logic                  out_valid;
  logic                  out_ready;
  logic                  result_valid;
  logic [COL_W-1:0]      center_col;
  logic [ROW_W-1:0]      center_row;
  logic                  center_pixel;
  logic [RUN_W-1:0]      run_count;
  logic                  is_junction;
  logic                  is_endpoint;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  int                    pending;
  int                    errors;
  int                    send_idle_pct;
  int                    recv_idle_pct;
  int                    hold_len;

  skeleton_junction_classifier DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .start_of_frame (start_of_frame),
    .pixel          (pixel),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .result_valid   (result_valid),
    .center_col     (center_col),
    .center_row     (center_row),
    .center_pixel   (center_pixel),
    .run_count      (run_count),
    .is_junction    (is_junction),
    .is_endpoint    (is_endpoint),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  sjc_result_checker result_check (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .start_of_frame (start_of_frame),
    .pixel          (pixel),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .result_valid   (result_valid),
    .center_col     (center_col),
    .center_row     (center_row),
    .center_pixel   (center_pixel),
    .run_count      (run_count),
    .is_junction    (is_junction),
    .is_endpoint    (is_endpoint),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pending        (pending),
    .errors         (errors)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: random stalls, plus an occasional long hold-off
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_len > 0) begin
        out_ready <= 1'b0;
        hold_len--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // entered and left at a falling edge
  task automatic apb_access(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                            input logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_pixel(input logic sof, input logic px);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    start_of_frame <= sof;
    pixel          <= px;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // random speckle or crossing lines, with stray frame starts as noise
  task automatic send_frame(input int width, input int rows, input int noise);
    int   kind;
    int   density;
    int   vcol;
    int   hrow;
    int   diag;
    logic px;
    kind    = $urandom_range(1);
    density = $urandom_range(5, 60);
    vcol    = $urandom_range(width - 1);
    hrow    = $urandom_range(rows - 1);
    diag    = $urandom_range(width - 1);
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < width; c++) begin
        if (kind == 0) px = ($urandom_range(99) < density);
        else px = (c == vcol) || (r == hrow) || (c == (r + diag) % width) ||
                  ($urandom_range(99) < 3);
        send_pixel((r == 0 && c == 0) || ($urandom_range(999) < noise), px);
      end
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    int raw_width;
    int width;
    int rows;
    int sent;
    bit paused;
    rst            = 1'b1;
    in_valid       = 1'b0;
    start_of_frame = 1'b0;
    pixel          = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    send_idle_pct  = 9;
    recv_idle_pct  = 88;
    hold_len       = 0;
    paused         = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    apb_access(1'b0, LINE_WIDTH_ADDR, '0);
    apb_access(1'b1, UNUSED_REG_ADDR, '1);
    apb_access(1'b0, LINE_WIDTH_ADDR, '0);
    apb_access(1'b1, LINE_WIDTH_ADDR, '1);
    apb_access(1'b0, LINE_WIDTH_ADDR, '0);
    apb_access(1'b1, LINE_WIDTH_ADDR, 5);
    for (int i = 0; i < 25; i++) send_pixel(i == 0, CROSS_PATTERN[24 - i]);
    drain();

    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 9 : (mode == 1) ? 88 : 0;
      recv_idle_pct = (mode == 0) ? 88 : (mode == 1) ? 9 : 0;
      for (int sub = 0; sub < 3; sub++) begin
        // widths 0..2 clamp to the minimum
        raw_width = (sub == 0) ? mode : $urandom_range(3, 24);
        width     = (raw_width < MIN_WIDTH) ? MIN_WIDTH : raw_width;
        apb_access(1'b1, LINE_WIDTH_ADDR, raw_width);
        apb_access(1'b0, LINE_WIDTH_ADDR, '0);
        if (mode == 2 && sub == 0) hold_len = 80;
        // leftover column position meets the new width
        repeat ($urandom_range(8)) send_pixel(1'b0, 1'($urandom_range(1)));
        sent = 0;
        while (sent < PHASE_ITEMS) begin
          rows = $urandom_range(1, 10);
          send_frame(width, rows, NOISE_PER_MILLE);
          sent += width * rows;
          if (mode == 2 && sub == 1 && !paused) begin
            drain();
            paused = 1'b1;
          end
        end
        drain();
      end
    end

    // full-width rows: the column counter must not wrap early
    apb_access(1'b1, LINE_WIDTH_ADDR, MAX_WIDTH);
    for (int i = 0; i < WIDE_ITEMS; i++) send_pixel(i == 0, 1'($urandom_range(1)));
    drain();

    repeat (10) @(posedge clk);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

[files.f]
hw/rtl/sjc_pkg.sv
hw/rtl/sjc_apb_regs.sv
hw/rtl/sjc_line_mem.sv
hw/rtl/sjc_window.sv
hw/rtl/skeleton_junction_classifier.sv
test/sjc_result_checker.sv
test/skeleton_junction_classifier_tb.sv
